/* src/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and the sine function of the grid raycaster.
// ----------------------------------------------------------------------------
package grc_pkg;
    localparam int SCREEN_WIDTH_DEF  = 1280;
    localparam int SCREEN_HEIGHT_DEF = 720;
    localparam int MAX_RANGE_DEF     = 32;

    localparam logic [15:0] STEP_Q10 = 16'd51;
    localparam logic [15:0] EDGE_Q10 = 16'd16384;

    localparam logic [2:0] REG_WALL0   = 3'd0;
    localparam logic [2:0] REG_WALL1   = 3'd1;
    localparam logic [2:0] REG_WALL2   = 3'd2;
    localparam logic [2:0] REG_WALL3   = 3'd3;
    localparam logic [2:0] REG_PX      = 3'd4;
    localparam logic [2:0] REG_PY      = 3'd5;
    localparam logic [2:0] REG_HEADING = 3'd6;

    typedef struct packed {
        logic [63:0] wall0;
        logic [63:0] wall1;
        logic [63:0] wall2;
        logic [63:0] wall3;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] heading;
    } t_cfg;

    function automatic logic [14:0] quarter_sine(input logic [4:0] i);
        case (i)
            5'd0:  quarter_sine = 15'd0;
            5'd1:  quarter_sine = 15'd1606;
            5'd2:  quarter_sine = 15'd3196;
            5'd3:  quarter_sine = 15'd4756;
            5'd4:  quarter_sine = 15'd6270;
            5'd5:  quarter_sine = 15'd7723;
            5'd6:  quarter_sine = 15'd9102;
            5'd7:  quarter_sine = 15'd10394;
            5'd8:  quarter_sine = 15'd11585;
            5'd9:  quarter_sine = 15'd12665;
            5'd10: quarter_sine = 15'd13623;
            5'd11: quarter_sine = 15'd14449;
            5'd12: quarter_sine = 15'd15137;
            5'd13: quarter_sine = 15'd15678;
            5'd14: quarter_sine = 15'd16069;
            5'd15: quarter_sine = 15'd16305;
            default: quarter_sine = 15'd16384;
        endcase
    endfunction

    function automatic logic signed [15:0] fixed_sine(input logic [15:0] a);
        logic [14:0] r;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [24:0] prod;
        logic [14:0] v;
        r = a[15] ^ 1'b0 ? 15'd0 : 15'd0;
        if (a[14]) r = 15'd16384 - {1'b0, a[13:0]};
        else       r = {1'b0, a[13:0]};
        if (r[14]) begin
            v = 15'd16384;
        end else begin
            lo   = quarter_sine({1'b0, r[13:10]});
            hi   = quarter_sine({1'b0, r[13:10]} + 5'd1);
            prod = 25'(hi - lo) * 25'(r[9:0]);
            v    = lo + prod[24:10];
        end
        fixed_sine = a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction
endpackage

/* src/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module grc_div
    import grc_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_try;

    assign n_try = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_try >= {1'b0, r_den}) begin
                    r_rem <= n_try - {1'b0, r_den};
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_try;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* src/grid_raycast_pixel_shader.sv */
// ----------------------------------------------------------------------------
// grid_raycast_pixel_shader
// One march step per S_CHECK/S_STEP pair, at most ceil(1024*MAX_RANGE/51) steps
// (643 by default), with separate adders for the two ray accumulators; then a
// bit-serial divide for the ceiling row. One word in flight; next word taken at the
// end of the strobe cycle. Receiver cannot stall. Synchronous active-low reset
// restores the register defaults and idles the sequencer.
// ----------------------------------------------------------------------------
module grid_raycast_pixel_shader
    import grc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int MAX_RANGE     = MAX_RANGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] i_pixel_column,
    input  logic [9:0]  i_pixel_row,
    output logic        o_valid,
    output logic [7:0]  o_grey_level,
    output logic        o_in_wall_band
);
    localparam int DLIM = MAX_RANGE * 1024;
    localparam int DW   = $clog2(DLIM + 64);
    localparam int HW   = $clog2(SCREEN_HEIGHT + 1);
    localparam int NW   = HW + DW + 2;
    localparam logic [30:0] COL_RECIP =
        31'(((64'd1 << 36) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    typedef enum logic [2:0] {
        S_IDLE, S_ANGLE, S_CHECK, S_STEP, S_DIV, S_WAIT, S_OUT
    } t_state;

    t_cfg r_cfg;
    t_state r_state;
    logic [10:0] r_col;
    logic [9:0]  r_row;
    logic [15:0] r_ang;
    logic signed [15:0] r_dx, r_dy;
    logic signed [31:0] r_ax, r_ay;
    logic [DW-1:0] r_d;
    logic r_div_go;
    logic [NW-1:0] quo;
    logic div_done;
    logic [7:0] r_grey;
    logic r_band, r_valid;

    logic wr;
    logic [2:0] widx;
    assign wr   = psel & penable & pwrite;
    assign widx = paddr[5:3];
    assign pready = 1'b1;

    always_comb begin
        case (paddr[5:3])
            REG_WALL0:   prdata = r_cfg.wall0;
            REG_WALL1:   prdata = r_cfg.wall1;
            REG_WALL2:   prdata = r_cfg.wall2;
            REG_WALL3:   prdata = r_cfg.wall3;
            REG_PX:      prdata = {48'd0, r_cfg.px};
            REG_PY:      prdata = {48'd0, r_cfg.py};
            REG_HEADING: prdata = {48'd0, r_cfg.heading};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{64'd0, 64'd0, 64'd0, 64'd0, 16'd32768, 16'd32768, 16'd0};
        end else if (wr) begin
            case (widx)
                REG_WALL0:   r_cfg.wall0   <= pwdata;
                REG_WALL1:   r_cfg.wall1   <= pwdata;
                REG_WALL2:   r_cfg.wall2   <= pwdata;
                REG_WALL3:   r_cfg.wall3   <= pwdata;
                REG_PX:      r_cfg.px      <= pwdata[15:0];
                REG_PY:      r_cfg.py      <= pwdata[15:0];
                REG_HEADING: r_cfg.heading <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // cell = trunc toward zero of accumulator / 2^24
    logic signed [7:0] cx, cy;
    logic out_x, out_y, edge_hit, wall;
    logic [3:0] mcol, mrow;
    logic [63:0] wrow;
    logic [5:0] wbit;
    always_comb begin
        cx = 8'(r_ax >>> 24);
        cy = 8'(r_ay >>> 24);
        if (r_ax < 0 && r_ax[23:0] != 24'd0) cx = cx + 8'sd1;
        if (r_ay < 0 && r_ay[23:0] != 24'd0) cy = cy + 8'sd1;
        out_x = (cx < 0) || (cx > 8'sd15);
        out_y = (cy < 0) || (cy > 8'sd15);
        edge_hit = out_x | out_y;
        mcol = cx[3:0];
        mrow = cy[3:0];
        case (mrow[3:2])
            2'd0:    wrow = r_cfg.wall0;
            2'd1:    wrow = r_cfg.wall1;
            2'd2:    wrow = r_cfg.wall2;
            default: wrow = r_cfg.wall3;
        endcase
        wbit = {mrow[1:0], mcol};
        wall = wrow[wbit];
    end

    // column * 8192 / SCREEN_WIDTH by reciprocal, exact for 11-bit columns
    logic [41:0] offs;
    assign offs = 42'(r_col) * 42'(COL_RECIP);

    // numerator H*d - 2048*H, treated signed; divide magnitude then fix sign
    logic signed [NW:0] num_s;
    logic [NW-1:0] num_mag;
    logic num_neg;
    assign num_s   = $signed({1'b0, (NW)'(SCREEN_HEIGHT) * (NW)'(r_d)})
                   - $signed((NW+1)'(SCREEN_HEIGHT * 2048));
    assign num_neg = num_s[NW];
    assign num_mag = num_neg ? NW'(-num_s) : NW'(num_s);

    grc_div #(.NUM_W(NW), .DEN_W(DW + 1)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  (num_mag),
        .i_den  ({r_d, 1'b0}),
        .o_done (div_done),
        .o_quo  (quo)
    );

    logic signed [NW:0] ceil_r, floor_r, row_s;
    logic in_band;
    logic [23:0] gprod;
    always_comb begin
        ceil_r  = num_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        floor_r = $signed((NW+1)'(SCREEN_HEIGHT)) - ceil_r;
        row_s   = $signed({{(NW-9){1'b0}}, r_row});
        in_band = (row_s > ceil_r) && (row_s <= floor_r);
        gprod   = 24'd255 * (24'(EDGE_Q10) - 24'(r_d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: if (start) begin
                    r_col   <= i_pixel_column;
                    r_row   <= i_pixel_row;
                    r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    r_ang   <= r_cfg.heading + offs[38:23] - 16'd4096;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_dx    <= fixed_sine(r_ang);
                    r_dy    <= fixed_sine(r_ang + 16'd16384);
                    r_ax    <= $signed({4'd0, r_cfg.px, 12'd0});
                    r_ay    <= $signed({4'd0, r_cfg.py, 12'd0});
                    r_d     <= '0;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_d >= DW'(DLIM)) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end else if (edge_hit) begin
                        r_d      <= DW'(EDGE_Q10);
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end else begin
                        r_d <= r_d + DW'(STEP_Q10);
                        if (wall) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_ax    <= r_ax + 32'(r_dx * 32'sd51);
                    r_ay    <= r_ay + 32'(r_dy * 32'sd51);
                    r_state <= S_CHECK;
                end
                S_DIV: if (div_done) begin
                    r_band  <= in_band;
                    r_grey  <= (in_band && r_d < DW'(EDGE_Q10)) ? gprod[21:14] : 8'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_grey_level   = r_grey;
    assign o_in_wall_band = r_band;

    a_busy_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("strobe while busy");
    a_grey_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_wall_band |-> o_grey_level == 8'd0) else $error("grey outside band");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("start not taken");
endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_raycast_pixel_shader: pixels are pushed through
// the start/busy port with random gaps, the scene is reprogrammed over APB
// between phases, and every result strobe is checked against a local ray march.
// ----------------------------------------------------------------------------
module tb_top
    import grc_pkg::*;
();

    localparam int SCR_W       = 1280;
    localparam int SCR_H       = 720;
    localparam int RANGE_Q10   = 32 * 1024;
    localparam int EDGE_DIST   = 16384;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SINE_TAB[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                    12665, 13623, 14449, 15137, 15678, 16069, 16305, 16384};

    typedef struct {
        logic [10:0] col;
        logic [9:0]  row;
    } t_pixel;

    typedef struct {
        logic [7:0] grey;
        logic       band;
    } t_shade;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [10:0] i_pixel_column;
    logic [9:0]  i_pixel_row;
    logic        o_valid;
    logic [7:0]  o_grey_level;
    logic        o_in_wall_band;

    t_cfg   scene;
    t_pixel pixel_q[$];
    t_shade shade_q[$];
    int     gap_left;
    int     idle_cycles = 0;
    int     errors = 0;
    int     queued = 0;
    int     checked = 0;

    grid_raycast_pixel_shader u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_valid        (o_valid),
        .o_grey_level   (o_grey_level),
        .o_in_wall_band (o_in_wall_band)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint ray_sine(logic [15:0] a);
        int r;
        int idx;
        int v;
        r = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
        idx = r >> 10;
        if (idx >= 16) v = 16384;
        else v = SINE_TAB[idx] + (((SINE_TAB[idx+1] - SINE_TAB[idx]) * (r & 1023)) >>> 10);
        return a[15] ? -longint'(v) : longint'(v);
    endfunction

    function automatic bit wall_at(longint cx, longint cy);
        int     r;
        int     c;
        logic [63:0] w;
        r = int'(cy) & 15;
        c = int'(cx) & 15;
        case (r >> 2)
            0: w = scene.wall0;
            1: w = scene.wall1;
            2: w = scene.wall2;
            default: w = scene.wall3;
        endcase
        return w[(r & 3) * 16 + c];
    endfunction

    function automatic t_shade trace_pixel(t_pixel p);
        t_shade      s;
        logic [15:0] ang;
        longint      dx, dy, bx, by, d, cx, cy, ceil_r, floor_r, row;
        bit          hit;
        ang = 16'(int'(scene.heading) + (int'(p.col) * 8192) / SCR_W + 65536 - 4096);
        dx  = ray_sine(ang);
        dy  = ray_sine(ang + 16'd16384);
        bx  = longint'(scene.px) * 4096;
        by  = longint'(scene.py) * 4096;
        row = longint'(p.row);
        d   = 0;
        s.grey = 8'd0;
        s.band = 1'b0;
        while (d < RANGE_Q10) begin
            cx = (bx + dx * d) / (longint'(1) << 24);
            cy = (by + dy * d) / (longint'(1) << 24);
            if (cx >= 16 || cx < 0 || cy >= 16 || cy < 0) begin
                d = EDGE_DIST;
                break;
            end
            hit = wall_at(cx, cy);
            d += 51;
            if (hit) break;
        end
        if (d == 0) begin
            s.grey = 8'd255;
            s.band = 1'b1;
        end else begin
            ceil_r  = (SCR_H * d - 2 * SCR_H * 1024) / (2 * d);
            floor_r = SCR_H - ceil_r;
            if (row > ceil_r && row <= floor_r) begin
                s.band = 1'b1;
                if (d < EDGE_DIST) s.grey = 8'((255 * (EDGE_DIST - d)) / EDGE_DIST);
            end
        end
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // driver: one start assignment per edge
    always @(posedge i_clk) begin
        logic   nxt_start;
        t_pixel p;
        if (!i_rst_n) begin
            start          <= 1'b0;
            gap_left       <= 0;
            i_pixel_column <= '0;
            i_pixel_row    <= '0;
        end else begin
            nxt_start = start;
            if (start && !busy) begin
                p.col = i_pixel_column;
                p.row = i_pixel_row;
                shade_q.push_back(trace_pixel(p));
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pixel_q.size() > 0) begin
                    p = pixel_q.pop_front();
                    i_pixel_column <= p.col;
                    i_pixel_row    <= p.row;
                    nxt_start = 1'b1;
                    gap_left <= pick_gap();
                end
            end
            start <= nxt_start;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_shade e;
        if (i_rst_n) begin
            if (o_valid) begin
                checked++;
                if (shade_q.size() == 0) begin
                    $display("%0t: unexpected word grey=%0d band=%0b", $time,
                             o_grey_level, o_in_wall_band);
                    errors++;
                end else begin
                    e = shade_q.pop_front();
                    if (e.grey !== o_grey_level) begin
                        $display("%0t: grey expected %0d actual %0d", $time, e.grey,
                                 o_grey_level);
                        errors++;
                    end
                    if (e.band !== o_in_wall_band) begin
                        $display("%0t: band expected %0b actual %0b", $time, e.band,
                                 o_in_wall_band);
                        errors++;
                    end
                end
            end
            if (o_valid || (start && !busy) || (psel && penable)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL grid_raycast_pixel_shader");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WALL0:   scene.wall0   = val;
            REG_WALL1:   scene.wall1   = val;
            REG_WALL2:   scene.wall2   = val;
            REG_WALL3:   scene.wall3   = val;
            REG_PX:      scene.px      = val[15:0];
            REG_PY:      scene.py      = val[15:0];
            REG_HEADING: scene.heading = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_scene(t_cfg s);
        write_reg(REG_WALL0, s.wall0);
        write_reg(REG_WALL1, s.wall1);
        write_reg(REG_WALL2, s.wall2);
        write_reg(REG_WALL3, s.wall3);
        write_reg(REG_PX, 64'(s.px));
        write_reg(REG_PY, 64'(s.py));
        write_reg(REG_HEADING, 64'(s.heading));
    endtask

    task automatic queue_pixel(int col, int row);
        t_pixel p;
        p.col = 11'(col);
        p.row = 10'(row);
        pixel_q.push_back(p);
        queued++;
    endtask

    // wait until every queued word has come back
    task automatic drain();
        while (checked < queued) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_walls();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: w = w & {$urandom, $urandom};
            1: w = w & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        t_cfg s;
        int   n;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        scene.wall0 = '0; scene.wall1 = '0; scene.wall2 = '0; scene.wall3 = '0;
        scene.px = 16'd32768; scene.py = 16'd32768; scene.heading = 16'd0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset scene: empty map, rays end at the map edge
        queue_pixel(0, 0);      queue_pixel(1279, 719);  queue_pixel(2047, 1023);
        queue_pixel(640, 360);  queue_pixel(640, 361);   queue_pixel(640, 500);
        queue_pixel(1280, 400); queue_pixel(1, 1022);
        drain();

        // player inside a wall: hit on first step, very tall band
        s = '{default: '1, px: 16'd0, py: 16'd0, heading: 16'd0};
        load_scene(s);
        queue_pixel(0, 0);    queue_pixel(1279, 719); queue_pixel(640, 360);
        queue_pixel(2047, 1023); queue_pixel(100, 512);
        drain();

        // map corner at zero and at the far extreme
        s = '{wall0: '0, wall1: '0, wall2: '0, wall3: '0, px: 16'd0, py: 16'd0,
              heading: 16'hFFFF};
        load_scene(s);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        queue_pixel(0, 360); queue_pixel(1279, 361); queue_pixel(640, 300);
        drain();
        write_reg(REG_PX, 64'hFFFF);
        write_reg(REG_PY, 64'hFFFF);
        queue_pixel(0, 360); queue_pixel(1279, 400); queue_pixel(640, 719);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            s.wall0 = random_walls(); s.wall1 = random_walls();
            s.wall2 = random_walls(); s.wall3 = random_walls();
            if (ph % 2 == 0) begin
                // closed room with the player kept off the border
                s.wall0 |= 64'h0000_0000_0000_FFFF;
                s.wall3 |= 64'hFFFF_0000_0000_0000;
                s.wall0 |= {4{16'h8001}}; s.wall1 |= {4{16'h8001}};
                s.wall2 |= {4{16'h8001}}; s.wall3 |= {4{16'h8001}};
                s.px = 16'($urandom_range(4096, 61439));
                s.py = 16'($urandom_range(4096, 61439));
            end else begin
                s.px = 16'($urandom);
                s.py = 16'($urandom);
            end
            s.heading = 16'($urandom);
            load_scene(s);
            n = $urandom_range(60, 85);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_pixel($urandom_range(0, 2047), $urandom_range(0, 1023));
                else
                    queue_pixel($urandom_range(0, 1279), $urandom_range(0, 719));
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS grid_raycast_pixel_shader");
        end else begin
            $display("FAIL grid_raycast_pixel_shader");
        end
        $finish;
    end
endmodule
